@@ design/shell_sort_engine_macros.svh @@
`ifndef SHELL_SORT_ENGINE_MACROS_SVH
`define SHELL_SORT_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define SSE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("shell sort engine check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define SSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("shell sort engine check failed");

`endif

@@ design/sse_pkg.sv @@
package sse_pkg;

   localparam int MAX_ITEMS_DEFAULT = 64;
   localparam int KEY_BITS_DEFAULT  = 32;
   localparam int KEY_IN_BITS       = 32;
   localparam int TAG_BITS          = 16;

   typedef struct packed {
      logic [KEY_IN_BITS-1:0] key;
      logic [TAG_BITS-1:0]    tag;
      logic                   last;
   } req_type;

   typedef struct packed {
      logic [KEY_IN_BITS-1:0] key_out;
      logic [TAG_BITS-1:0]    tag_out;
      logic                   last_out;
      logic                   overflow;
   } rsp_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic load;       // store the incoming record
      logic gap_first;  // first gap from the record count
      logic gap_next;   // next gap from the current one
      logic read_cur;   // read the record at position i
      logic load_cur;   // latch it as the moving record, read i - gap
      logic compare;    // compare, write at j + gap, walk down on a shift
      logic put;        // place the moving record at j
      logic next_i;     // advance to the next position
      logic emit;       // read the next sorted record out
      logic end_batch;  // clear count, read index and drop flag
   } cmd_type;

   typedef struct packed {
      logic fill_zero;
      logic fill_lt2;
      logic gap_one;
      logic gt;         // earlier key above the moving key
      logic walk_on;    // shift and keep walking down
      logic more_i;     // another position remains in this pass
      logic emit_last;  // the read issued now is the final record
   } status_type;

endpackage

@@ design/shell_sort_engine.sv @@
// Batch sorter. Records (key, tag) are taken one per cycle while busy is low;
// a record with last set closes the batch. Up to MAX_ITEMS records are held;
// further records, a last one included, are dropped and the batch's results
// carry overflow. Keys keep their low KEY_BITS bits and sort ascending as
// unsigned; records with equal keys come out in the order a shell sort with
// gaps (n/8*3)|1, (gap/8*3)|1, ..., 1 leaves them. After last, busy stays
// high while the sort runs on a record memory with one read and one write
// port: a setup step, a gap step before each pass after the first, and per
// position visited in a pass a read, a latch and a compare step plus one
// step per record shifted. The sorted records then leave one per cycle,
// each result in the cycle after its read; the final one has last_out set. A
// batch of one record comes straight out. rsp_valid marks each result for
// exactly one cycle and the receiver cannot stall it; a new batch may start
// loading while the final result of the previous one is on the ports.
module shell_sort_engine #(
   parameter int MAX_ITEMS = sse_pkg::MAX_ITEMS_DEFAULT,
   parameter int KEY_BITS  = sse_pkg::KEY_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sse_pkg::req_type  req_data,
   output logic              rsp_valid,
   output sse_pkg::rsp_type  rsp_data
);
   import sse_pkg::*;

   cmd_type    cmd;
   status_type status;

   sse_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_last (req_data.last),
      .busy     (busy),
      .cmd      (cmd),
      .status   (status)
   );

   sse_dpath #(
      .MAX_ITEMS (MAX_ITEMS),
      .KEY_BITS  (KEY_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

@@ design/sse_ctrl.sv @@
module sse_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_last,
   output logic                 busy,
   output sse_pkg::cmd_type     cmd,
   input  sse_pkg::status_type  status
);
   import sse_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_SETUP = 8'b00000010,
      S_GAP   = 8'b00000100,
      S_RDCUR = 8'b00001000,
      S_LDCUR = 8'b00010000,
      S_CMP   = 8'b00100000,
      S_PUT   = 8'b01000000,
      S_EMIT  = 8'b10000000
   } state_type;

   state_type state_ff;
   state_type state_in;
   state_type pass_next;

   assign busy = (state_ff != S_IDLE);

   // where to go once the moving record is placed
   assign pass_next = status.more_i  ? S_RDCUR :
                      status.gap_one ? S_EMIT  : S_GAP;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  state_in = S_SETUP;
               end
            end
         end
         S_SETUP: begin
            priority if (status.fill_zero) begin
               cmd.end_batch = 1'b1;
               state_in      = S_IDLE;
            end else if (status.fill_lt2) begin
               state_in = S_EMIT;
            end else begin
               cmd.gap_first = 1'b1;
               state_in      = S_RDCUR;
            end
         end
         S_GAP: begin
            cmd.gap_next = 1'b1;
            state_in     = S_RDCUR;
         end
         S_RDCUR: begin
            cmd.read_cur = 1'b1;
            state_in     = S_LDCUR;
         end
         S_LDCUR: begin
            cmd.load_cur = 1'b1;
            state_in     = S_CMP;
         end
         S_CMP: begin
            // a shift with no earlier record left places the moving record in S_PUT
            cmd.compare = 1'b1;
            if (status.walk_on) begin
               state_in = S_CMP;
            end else if (status.gt) begin
               state_in = S_PUT;
            end else begin
               cmd.next_i = 1'b1;
               state_in   = pass_next;
            end
         end
         S_PUT: begin
            cmd.put    = 1'b1;
            cmd.next_i = 1'b1;
            state_in   = pass_next;
         end
         S_EMIT: begin
            cmd.emit = 1'b1;
            if (status.emit_last) begin
               cmd.end_batch = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/sse_dpath.sv @@
module sse_dpath #(
   parameter int MAX_ITEMS = sse_pkg::MAX_ITEMS_DEFAULT,
   parameter int KEY_BITS  = sse_pkg::KEY_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sse_pkg::cmd_type     cmd,
   output sse_pkg::status_type  status,
   input  sse_pkg::req_type     req_data,
   output logic                 rsp_valid,
   output sse_pkg::rsp_type     rsp_data
);
   import sse_pkg::*;

   localparam int AW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);

   logic [KEY_BITS-1:0] key_mem [MAX_ITEMS];
   logic [TAG_BITS-1:0] tag_mem [MAX_ITEMS];

   logic [CW-1:0]       fill_ff, fill_in;
   logic                dropped_ff, dropped_in;
   logic [CW-1:0]       gap_ff, gap_in;
   logic [CW-1:0]       i_ff, i_in;
   logic [CW-1:0]       j_ff, j_in;
   logic [CW-1:0]       k_ff, k_in;
   logic [KEY_BITS-1:0] cur_key_ff, cur_key_in;
   logic [TAG_BITS-1:0] cur_tag_ff, cur_tag_in;
   logic [KEY_BITS-1:0] rd_key_ff;
   logic [TAG_BITS-1:0] rd_tag_ff;
   logic                out_valid_ff, out_valid_in;
   logic                out_last_ff, out_last_in;
   logic                out_ovf_ff, out_ovf_in;

   logic [KEY_BITS+KEY_IN_BITS-1:0] key_wide;
   logic [KEY_BITS-1:0]             key_trim;
   logic [KEY_IN_BITS+KEY_BITS-1:0] out_wide;
   logic [CW-1:0]                   gap_src;
   logic [CW-1:0]                   eighth;
   logic [CW+1:0]                   trip;
   logic [CW-1:0]                   gap_new;
   logic [CW:0]                     i_plus;
   logic [CW:0]                     k_plus;
   logic [CW-1:0]                   j_up;
   logic [CW-1:0]                   j_dn;
   logic [CW-1:0]                   i_dn;
   logic                            fill_full;
   logic                            gt;
   logic                            j_ge_gap;

   logic                wr_en;
   logic [AW-1:0]       waddr;
   logic [KEY_BITS-1:0] wkey;
   logic [TAG_BITS-1:0] wtag;
   logic                rd_en;
   logic [AW-1:0]       raddr;

   assign key_wide = {{KEY_BITS{1'b0}}, req_data.key};
   assign key_trim = key_wide[KEY_BITS-1:0];
   assign out_wide = {{KEY_IN_BITS{1'b0}}, rd_key_ff};

   // gap' = (gap / 8 * 3) | 1
   assign gap_src = cmd.gap_first ? fill_ff : gap_ff;
   assign eighth  = gap_src >> 3;
   assign trip    = {2'b00, eighth} + {1'b0, eighth, 1'b0};
   assign gap_new = trip[CW-1:0] | CW'(1);

   assign i_plus    = {1'b0, i_ff} + 1'b1;
   assign k_plus    = {1'b0, k_ff} + 1'b1;
   assign j_up      = j_ff + gap_ff;
   assign j_dn      = j_ff - gap_ff;
   assign i_dn      = i_ff - gap_ff;
   assign fill_full = (fill_ff >= CW'(MAX_ITEMS));
   assign gt        = (rd_key_ff > cur_key_ff);
   assign j_ge_gap  = (j_ff >= gap_ff);

   assign status.fill_zero = (fill_ff == '0);
   assign status.fill_lt2  = (fill_ff < CW'(2));
   assign status.gap_one   = (gap_ff == CW'(1));
   assign status.gt        = gt;
   assign status.walk_on   = gt && j_ge_gap;
   assign status.more_i    = (i_plus < {1'b0, fill_ff});
   assign status.emit_last = (k_plus == {1'b0, fill_ff});

   always_comb begin
      wr_en = 1'b0;
      waddr = fill_ff[AW-1:0];
      wkey  = key_trim;
      wtag  = req_data.tag;
      if (cmd.load && !fill_full) begin
         wr_en = 1'b1;
      end
      if (cmd.compare) begin
         wr_en = 1'b1;
         waddr = j_up[AW-1:0];
         wkey  = gt ? rd_key_ff : cur_key_ff;
         wtag  = gt ? rd_tag_ff : cur_tag_ff;
      end
      if (cmd.put) begin
         wr_en = 1'b1;
         waddr = j_ff[AW-1:0];
         wkey  = cur_key_ff;
         wtag  = cur_tag_ff;
      end
   end

   always_comb begin
      rd_en = 1'b0;
      raddr = k_ff[AW-1:0];
      priority if (cmd.read_cur) begin
         rd_en = 1'b1;
         raddr = i_ff[AW-1:0];
      end else if (cmd.load_cur) begin
         rd_en = 1'b1;
         raddr = i_dn[AW-1:0];
      end else if (cmd.compare && status.walk_on) begin
         rd_en = 1'b1;
         raddr = j_dn[AW-1:0];
      end else if (cmd.emit) begin
         rd_en = 1'b1;
      end else begin
         rd_en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[waddr] <= wkey;
         tag_mem[waddr] <= wtag;
      end
      if (rd_en) begin
         rd_key_ff <= key_mem[raddr];
         rd_tag_ff <= tag_mem[raddr];
      end
   end

   always_comb begin
      fill_in      = fill_ff;
      dropped_in   = dropped_ff;
      gap_in       = gap_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      cur_key_in   = cur_key_ff;
      cur_tag_in   = cur_tag_ff;
      out_valid_in = cmd.emit;
      out_last_in  = status.emit_last;
      out_ovf_in   = dropped_ff;
      if (cmd.load) begin
         if (fill_full) begin
            dropped_in = 1'b1;
         end else begin
            fill_in = fill_ff + 1'b1;
         end
      end
      if (cmd.gap_first || cmd.gap_next) begin
         gap_in = gap_new;
         i_in   = gap_new;
      end
      if (cmd.load_cur) begin
         cur_key_in = rd_key_ff;
         cur_tag_in = rd_tag_ff;
         j_in       = i_dn;
      end
      if (cmd.compare && status.walk_on) begin
         j_in = j_dn;
      end
      if (cmd.next_i) begin
         i_in = i_plus[CW-1:0];
      end
      if (cmd.emit) begin
         k_in = k_plus[CW-1:0];
      end
      if (cmd.end_batch) begin
         fill_in    = '0;
         dropped_in = 1'b0;
         k_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         dropped_ff   <= 1'b0;
         k_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         dropped_ff   <= dropped_in;
         k_ff         <= k_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      gap_ff      <= gap_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      cur_key_ff  <= cur_key_in;
      cur_tag_ff  <= cur_tag_in;
      out_last_ff <= out_last_in;
      out_ovf_ff  <= out_ovf_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_data.key_out  = out_wide[KEY_IN_BITS-1:0];
   assign rsp_data.tag_out  = rd_tag_ff;
   assign rsp_data.last_out = out_last_ff;
   assign rsp_data.overflow = out_ovf_ff;

endmodule

@@ design/sse_checker.sv @@
`include "shell_sort_engine_macros.svh"

module sse_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input sse_pkg::req_type  req_data,
   input logic              rsp_valid,
   input sse_pkg::rsp_type  rsp_data
);
   import sse_pkg::*;

   // results only come out of a batch that was being worked on
   `SSE_ASSERT_NOW(a_rsp_after_busy, clock, reset, rsp_valid, $past(busy))
   `SSE_ASSERT_NEXT(a_last_goes_busy, clock, reset, start && !busy && req_data.last, busy)
   // results of one batch leave back to back and end with the marked one
   `SSE_ASSERT_NEXT(a_rsp_run_on, clock, reset, rsp_valid && !rsp_data.last_out, rsp_valid)
   `SSE_ASSERT_NEXT(a_rsp_run_ends, clock, reset, rsp_valid && rsp_data.last_out, !rsp_valid)
   `SSE_ASSERT_NOW(a_rsp_mid_busy, clock, reset, rsp_valid && !rsp_data.last_out, busy)

endmodule

bind shell_sort_engine sse_checker u_sse_checker (.*);

@@ bench/shell_sort_engine_tb.sv @@
`timescale 1ns / 1ps

module shell_sort_engine_tb;
   import sse_pkg::*;

   localparam int MAX_ITEMS = MAX_ITEMS_DEFAULT;
   localparam int KEY_BITS  = KEY_BITS_DEFAULT;
   localparam int RECORD_TARGET = 370;
   localparam int REPORT_LIMIT  = 10;

   typedef enum {
      KEYS_RANDOM,
      KEYS_TIED,
      KEYS_RISING,
      KEYS_FALLING,
      KEYS_EXTREME
   } key_pattern_type;

   // Mirror of the record memory; predicts the sorted batch on each last record.
   class sorted_batch_type;
      logic [KEY_IN_BITS-1:0] held_key[MAX_ITEMS];
      logic [TAG_BITS-1:0]    held_tag[MAX_ITEMS];
      int                     fill;
      bit                     dropped;
      rsp_type                sorted_due[$];
      int                     mismatches;

      function new();
         fill = 0;
         dropped = 0;
         mismatches = 0;
      endfunction

      function logic [KEY_IN_BITS-1:0] key_mask();
         if (KEY_BITS >= KEY_IN_BITS)
            return '1;
         return (32'd1 << KEY_BITS) - 32'd1;
      endfunction

      function void shell_sort(int n);
         int gap;
         int i;
         int j;
         logic [KEY_IN_BITS-1:0] k;
         logic [TAG_BITS-1:0]    t;
         if (n < 2)
            return;
         gap = n;
         do begin
            gap = (gap / 8 * 3) | 1;
            for (i = gap; i < n; i++) begin
               for (j = i - gap; j >= 0; j -= gap) begin
                  if (held_key[j] <= held_key[j + gap])
                     break;
                  k = held_key[j];
                  t = held_tag[j];
                  held_key[j] = held_key[j + gap];
                  held_tag[j] = held_tag[j + gap];
                  held_key[j + gap] = k;
                  held_tag[j + gap] = t;
               end
            end
         end while (gap != 1);
      endfunction

      function void note_record(req_type r);
         rsp_type want;
         int k;
         if (fill < MAX_ITEMS) begin
            held_key[fill] = r.key & key_mask();
            held_tag[fill] = r.tag;
            fill++;
         end else begin
            dropped = 1'b1;
         end
         if (r.last) begin
            shell_sort(fill);
            for (k = 0; k < fill; k++) begin
               want.key_out  = held_key[k];
               want.tag_out  = held_tag[k];
               want.last_out = (k == fill - 1);
               want.overflow = dropped;
               sorted_due.push_back(want);
            end
            fill = 0;
            dropped = 1'b0;
         end
      endfunction

      function void report(string what, rsp_type want, rsp_type got);
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display({"%0t %s: expected key %h tag %h last %b ovf %b,",
                      " got key %h tag %h last %b ovf %b"},
                     $realtime, what, want.key_out, want.tag_out, want.last_out,
                     want.overflow, got.key_out, got.tag_out, got.last_out,
                     got.overflow);
      endfunction

      function void check_record(rsp_type got);
         rsp_type want;
         if (sorted_due.size() == 0) begin
            want = '0;
            report("unexpected result", want, got);
            return;
         end
         want = sorted_due.pop_front();
         if (got.key_out !== want.key_out || got.tag_out !== want.tag_out ||
             got.last_out !== want.last_out || got.overflow !== want.overflow)
            report("result mismatch", want, got);
      endfunction

      function int pending();
         return sorted_due.size();
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   sorted_batch_type tracker;
   int idle_pct;
   int records_sent;

   shell_sort_engine #(
      .MAX_ITEMS(MAX_ITEMS),
      .KEY_BITS(KEY_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         tracker.check_record(rsp_data);
   end

   task automatic send_record(input logic [KEY_IN_BITS-1:0] key,
                              input logic [TAG_BITS-1:0] tag, input logic last);
      req_type r;
      r.key  = key;
      r.tag  = tag;
      r.last = last;
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      // hold the transaction until an edge sees busy low
      while (busy)
         @(posedge clock);
      tracker.note_record(r);
      records_sent++;
   endtask

   task automatic send_batch(input int n, input key_pattern_type pat);
      logic [KEY_IN_BITS-1:0] base;
      logic [KEY_IN_BITS-1:0] key;
      int k;
      base = $urandom;
      for (k = 0; k < n; k++) begin
         case (pat)
            KEYS_RANDOM:  key = $urandom;
            KEYS_TIED:    key = base + $urandom_range(0, 3);
            KEYS_RISING:  key = base + k;
            KEYS_FALLING: key = base - k;
            default:      key = $urandom_range(0, 1) ? '1 : '0;
         endcase
         send_record(key, 16'($urandom), k == n - 1);
      end
   endtask

   initial begin
      int k;
      int n;
      int pick;
      int batch_no;
      tracker = new();
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      idle_pct = 25;
      records_sent = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // single-record batches at both extremes pass straight through
      send_record(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
      send_record(32'h0000_0000, 16'h0000, 1'b1);
      // descending pair, then an equal-key pair whose order must hold
      send_record(32'hFFFF_FFFF, 16'h0001, 1'b0);
      send_record(32'h0000_0000, 16'h0002, 1'b1);
      send_record(32'h0000_0005, 16'hAAAA, 1'b0);
      send_record(32'h0000_0005, 16'h5555, 1'b1);
      // nine falling keys with ties: a gap of three precedes the final pass
      for (k = 0; k < 9; k++)
         send_record(32'((8 - k) >> 1), 16'(16'h0100 + k), k == 8);
      // eight records mixing keys just above and just below the unsigned midpoint
      for (k = 0; k < 8; k++)
         send_record((k % 3 == 0) ? 32'h8000_0000 + k : 32'h7FFF_FFFF - k,
                     16'(16'hF000 + k), k == 7);

      batch_no = 0;
      while (records_sent < RECORD_TARGET) begin
         if (records_sent < RECORD_TARGET * 37 / 100)
            idle_pct = 25;
         else if (records_sent < RECORD_TARGET * 68 / 100)
            idle_pct = 64;
         else
            idle_pct = 0;
         pick = $urandom_range(0, 99);
         if (batch_no == 2)
            n = MAX_ITEMS;
         else if (batch_no == 6)
            n = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
         else if (pick < 70)
            n = $urandom_range(1, 12);
         else if (pick < 90)
            n = $urandom_range(13, 40);
         else if (pick < 97)
            n = $urandom_range(41, MAX_ITEMS);
         else
            n = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
         send_batch(n, key_pattern_type'($urandom_range(0, 4)));
         batch_no++;
      end
      start <= 1'b0;

      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
